// ===== rtl/core/stpr_pkg.sv =====
`timescale 1ns / 1ps

package stpr_pkg;

  localparam int unsigned COUNT_BITS   = 24;
  localparam int unsigned PERIOD_BITS  = 16;
  localparam int unsigned CURRENT_BITS = 12;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_BITS     = 16;

  localparam logic [CURRENT_BITS-1:0] STOP_CURRENT = CURRENT_BITS'(64);

  localparam logic [PERIOD_BITS-1:0]  SLOW_PERIOD_RST = PERIOD_BITS'(800);
  localparam logic [PERIOD_BITS-1:0]  FAST_PERIOD_RST = PERIOD_BITS'(100);
  localparam logic [PERIOD_BITS-1:0]  RAMP_STEP_RST   = PERIOD_BITS'(10);
  localparam logic [CURRENT_BITS-1:0] RUN_CURRENT_RST = '0;

  typedef enum logic [1:0] {
    ST_STOP   = 2'd0,
    ST_ACCEL  = 2'd1,
    ST_CRUISE = 2'd2,
    ST_BRAKE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_RAMP  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SLOW_PERIOD = 3'd0,
    CFG_FAST_PERIOD = 3'd1,
    CFG_RAMP_STEP   = 3'd2,
    CFG_RUN_CURRENT = 3'd3,
    CFG_BLDC_STOP   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]            command;
    logic [COUNT_BITS-1:0] move_steps;
    logic                  move_direction;
  } req_t;

  typedef struct packed {
    logic [1:0]              motion_status;
    logic [PERIOD_BITS-1:0]  step_period;
    logic                    pulse_enable;
    logic                    ramp_enable;
    logic                    direction_out;
    logic [CURRENT_BITS-1:0] current_out;
    logic                    move_done;
    logic                    cruise_clamped;
  } rsp_t;

endpackage

// ===== rtl/core/stepper_trapezoid_ramp_control.sv =====
`timescale 1ns / 1ps

// Trapezoidal step-rate profiler for a stepper drive, driven by events.
//
// Input channel (in_valid_i / in_stall_o / in_req_i): one request per event,
// either a start command, a ramp tick or one counted step. Output channel
// (out_valid_o / out_stall_i / out_rsp_o): exactly one response per request,
// carrying the motion state after that request plus done and clamp flags.
//
// A response is registered in the response register, or in the skid
// register while the receiver stalls. One request is taken per cycle while
// in_stall_o is low; all profile arithmetic (one add, one compare, one
// subtract per path) sits between the state and response registers.
//
// When the receiver stalls, the response register holds and one more
// response lands in a skid register; in_stall_o is high while the skid
// register is full, so the input stalls until it has drained.
//
// Reset clears the motion state to stopped with period, counters and current
// at zero, and loads the configuration registers with their defaults.
// Configuration writes (cfg_we_i) take effect at the next edge.
module stepper_trapezoid_ramp_control (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [stpr_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [stpr_pkg::CFG_BITS-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  stpr_pkg::req_t                      in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output stpr_pkg::rsp_t                      out_rsp_o
);
  import stpr_pkg::*;

  // configuration
  logic [PERIOD_BITS-1:0]  slow_period_q, fast_period_q, ramp_step_q;
  logic [CURRENT_BITS-1:0] run_current_q;
  logic                    bldc_stop_q;

  // motion state
  status_e                 status_q, status_d;
  logic [PERIOD_BITS-1:0]  period_q, period_d;
  logic [COUNT_BITS-1:0]   step_count_q, step_count_d;
  logic [COUNT_BITS-1:0]   count_limit_q, count_limit_d;
  logic [COUNT_BITS-1:0]   total_q, total_d;
  logic [COUNT_BITS-1:0]   passed_q, passed_d;
  logic [COUNT_BITS-1:0]   accel_q, accel_d;
  logic [COUNT_BITS-1:0]   cruise_q, cruise_d;
  logic                    dir_q, dir_d;
  logic                    pulse_on_q, pulse_on_d;
  logic                    ramp_on_q, ramp_on_d;
  logic [CURRENT_BITS-1:0] current_q, current_d;

  // response path
  rsp_t out_q, skid_q, rsp;
  logic out_valid_q, skid_valid_q;
  logic in_acc, out_fire;
  logic done, clamped;

  // profile arithmetic
  logic [PERIOD_BITS:0]  fast_plus_ramp, period_plus_ramp;
  logic [COUNT_BITS+1:0] cruise_a, cruise_b, cruise_diff;
  logic [COUNT_BITS-1:0] passed_sum;

  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_rsp_o   = out_q;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_period_q <= SLOW_PERIOD_RST;
      fast_period_q <= FAST_PERIOD_RST;
      ramp_step_q   <= RAMP_STEP_RST;
      run_current_q <= RUN_CURRENT_RST;
      bldc_stop_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLOW_PERIOD: slow_period_q <= cfg_data_i[PERIOD_BITS-1:0];
        CFG_FAST_PERIOD: fast_period_q <= cfg_data_i[PERIOD_BITS-1:0];
        CFG_RAMP_STEP:   ramp_step_q   <= cfg_data_i[PERIOD_BITS-1:0];
        CFG_RUN_CURRENT: run_current_q <= cfg_data_i[CURRENT_BITS-1:0];
        CFG_BLDC_STOP:   bldc_stop_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Widened sums so the end-of-ramp compares never wrap.
  assign fast_plus_ramp   = {1'b0, fast_period_q} + {1'b0, ramp_step_q};
  assign period_plus_ramp = {1'b0, period_q} + {1'b0, ramp_step_q};

  // Cruise length (total + 1) - (accel + 2) * 2, with accel taken from the
  // step counter at the moment acceleration ends.
  assign cruise_a    = (COUNT_BITS+2)'(total_q) + (COUNT_BITS+2)'(1);
  assign cruise_b    = ((COUNT_BITS+2)'(step_count_q) + (COUNT_BITS+2)'(2)) << 1;
  assign cruise_diff = cruise_a - cruise_b;

  // Steps passed once cruise is over.
  assign passed_sum = passed_q + cruise_q;

  always_comb begin
    status_d      = status_q;
    period_d      = period_q;
    step_count_d  = step_count_q;
    count_limit_d = count_limit_q;
    total_d       = total_q;
    passed_d      = passed_q;
    accel_d       = accel_q;
    cruise_d      = cruise_q;
    dir_d         = dir_q;
    pulse_on_d    = pulse_on_q;
    ramp_on_d     = ramp_on_q;
    current_d     = current_q;
    done          = 1'b0;
    clamped       = 1'b0;

    if (in_acc) begin
      case (in_req_i.command)
        CMD_START: begin
          // Restart from scratch, even in the middle of a move.
          total_d       = in_req_i.move_steps - COUNT_BITS'(1);
          count_limit_d = in_req_i.move_steps - COUNT_BITS'(1);
          passed_d      = '0;
          step_count_d  = '0;
          dir_d         = in_req_i.move_direction;
          current_d     = run_current_q;
          period_d      = slow_period_q;
          status_d      = ST_ACCEL;
          pulse_on_d    = 1'b1;
          ramp_on_d     = 1'b1;
        end
        CMD_RAMP: begin
          if (ramp_on_q && status_q == ST_ACCEL) begin
            if ({1'b0, period_q} <= fast_plus_ramp) begin
              // Top speed reached: latch the ramp length, plan the cruise.
              accel_d   = step_count_q;
              passed_d  = passed_q + step_count_q;
              period_d  = fast_period_q;
              status_d  = ST_CRUISE;
              ramp_on_d = 1'b0;
              if (cruise_b > cruise_a) begin
                cruise_d = '0;
                clamped  = 1'b1;
              end else begin
                cruise_d = cruise_diff[COUNT_BITS-1:0];
              end
              count_limit_d = cruise_d;
            end else begin
              period_d = period_q - ramp_step_q;
            end
          end else if (ramp_on_q && status_q == ST_BRAKE) begin
            if (period_plus_ramp >= {1'b0, slow_period_q}) begin
              period_d = slow_period_q;
              if (bldc_stop_q) begin
                pulse_on_d   = 1'b0;
                ramp_on_d    = 1'b0;
                current_d    = STOP_CURRENT;
                status_d     = ST_STOP;
                step_count_d = '0;
                total_d      = '0;
                passed_d     = '0;
                accel_d      = '0;
                done         = 1'b1;
              end else begin
                ramp_on_d = 1'b0;
              end
            end else begin
              period_d = period_plus_ramp[PERIOD_BITS-1:0];
            end
          end
        end
        CMD_STEP: begin
          // Count every step; wrap at the limit; cruise and brake act on the wrap.
          if (step_count_q >= count_limit_q) begin
            step_count_d = '0;
            if (status_q == ST_CRUISE) begin
              passed_d = passed_sum;
              if (passed_sum > total_q) begin
                count_limit_d = '0;
                clamped       = 1'b1;
              end else begin
                count_limit_d = total_q - passed_sum;
              end
              status_d  = ST_BRAKE;
              ramp_on_d = 1'b1;
            end else if (status_q == ST_BRAKE) begin
              pulse_on_d   = 1'b0;
              ramp_on_d    = 1'b0;
              current_d    = STOP_CURRENT;
              status_d     = ST_STOP;
              step_count_d = '0;
              total_d      = '0;
              passed_d     = '0;
              accel_d      = '0;
              done         = 1'b1;
            end
          end else begin
            step_count_d = step_count_q + COUNT_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rsp.motion_status  = status_d;
    rsp.step_period    = period_d;
    rsp.pulse_enable   = pulse_on_d;
    rsp.ramp_enable    = ramp_on_d;
    rsp.direction_out  = dir_d;
    rsp.current_out    = current_d;
    rsp.move_done      = done;
    rsp.cruise_clamped = clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q      <= ST_STOP;
      period_q      <= '0;
      step_count_q  <= '0;
      count_limit_q <= '0;
      total_q       <= '0;
      passed_q      <= '0;
      accel_q       <= '0;
      cruise_q      <= '0;
      dir_q         <= 1'b0;
      pulse_on_q    <= 1'b0;
      ramp_on_q     <= 1'b0;
      current_q     <= '0;
    end else begin
      status_q      <= status_d;
      period_q      <= period_d;
      step_count_q  <= step_count_d;
      count_limit_q <= count_limit_d;
      total_q       <= total_d;
      passed_q      <= passed_d;
      accel_q       <= accel_d;
      cruise_q      <= cruise_d;
      dir_q         <= dir_d;
      pulse_on_q    <= pulse_on_d;
      ramp_on_q     <= ramp_on_d;
      current_q     <= current_d;
    end
  end

  // Response register plus one skid slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_fire) begin
        out_q <= rsp;
      end else begin
        skid_q <= rsp;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while response register empty");

  a_stop_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q == ST_STOP) |-> (!ramp_on_q && (pulse_on_q == 1'b0)))
    else $error("pulses or ramp active while stopped");

  a_cruise_no_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q == ST_CRUISE) |-> !ramp_on_q)
    else $error("ramp active while cruising");

  a_done_is_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.move_done) |-> (out_q.motion_status == ST_STOP))
    else $error("move done reported with motion still running");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted request produced no response");
`endif

endmodule
